// ===== src/assert_macros.svh =====
// Assertion helpers included by the activated_dot_product_core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked implication check, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// Same check, never disabled.
`define ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/adp_pkg.sv =====
`default_nettype none

package adp_pkg;

	localparam int LEFT_W  = 32;
	localparam int RIGHT_W = 16;
	localparam int PROD_W  = LEFT_W + RIGHT_W;
	localparam int SUM_W   = 64;
	localparam int CFG_W   = 32;

	// Activation mode codes; bit 1 selects clipping (code 3 also clips).
	localparam logic [1:0] MODE_NONE = 2'd0;
	localparam logic [1:0] MODE_RELU = 2'd1;
	localparam logic [1:0] MODE_CLIP = 2'd2;

	// Register indexes
	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	localparam logic [1:0]               MODE_RST  = MODE_RELU;
	localparam logic signed [LEFT_W-1:0] LIMIT_RST = 32'sd127;

	typedef struct packed {
		logic [1:0]               mode;
		logic signed [LEFT_W-1:0] limit;
	} cfg_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prod;
		logic                     last;
		logic                     zero;  // clip mode with non-positive limit
	} stage_t;

endpackage

`default_nettype wire

// ===== src/adp_config.sv =====
`default_nettype none

module adp_config
	import adp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	logic [1:0]               mode_q;
	logic signed [LEFT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[1:0];
				REG_LIMIT: limit_q <= $signed(cfg_data[LEFT_W-1:0]);
				default:   ;
			endcase
		end
	end

	assign cfg.mode  = mode_q;
	assign cfg.limit = limit_q;

endmodule

`default_nettype wire

// ===== src/adp_mul.sv =====
`default_nettype none

module adp_mul
	import adp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      load,
	input  wire logic signed [LEFT_W-1:0]  left_s1,
	input  wire logic signed [RIGHT_W-1:0] right_s1,
	input  wire logic                      last_s1,
	input  wire cfg_t                      cfg,
	output stage_t                         stage_s2
);

	logic                     clip;
	logic                     lim_pos;
	logic signed [LEFT_W-1:0] act;
	stage_t                   stage_d;

	assign clip    = cfg.mode[1];
	assign lim_pos = cfg.limit > 0;

	always_comb begin
		if (clip) begin
			if (!lim_pos || left_s1 < 0)
				act = '0;
			else if (left_s1 > cfg.limit)
				act = cfg.limit;
			else
				act = left_s1;
		end else if (cfg.mode == MODE_RELU) begin
			act = (left_s1 < 0) ? '0 : left_s1;
		end else begin
			act = left_s1;
		end
	end

	always_comb begin
		stage_d.prod = PROD_W'(act) * PROD_W'(right_s1);
		stage_d.last = last_s1;
		stage_d.zero = clip && !lim_pos;
	end

	// payload only, qualified by the valid bit in the parent
	always_ff @(posedge clk) begin
		if (load)
			stage_s2 <= stage_d;
	end

endmodule

`default_nettype wire

// ===== src/activated_dot_product_core.sv =====
// activated_dot_product_core: streaming multiply-accumulate with activation.
//
// Input channel (in_valid/in_ready): one transaction carries left_value (signed
// 32-bit activation), right_value (signed 16-bit weight) and last_item. The
// configured activation (none, ReLU, clipped ReLU) is applied to left_value,
// the result is multiplied by right_value and added to a 64-bit wrapping sum.
// Output channel (out_valid/out_ready): a transaction with last_item set yields
// one dot_sum transaction and clears the sum; other transactions yield none.
// In clip mode with clip_limit <= 0 the emitted dot_sum is zero.
// Config port: cfg_we/cfg_index/cfg_data, write only, while the core is idle.
// Pipeline: input register, multiply register, accumulate/output register.
// Throughput: one pair per cycle, set by the single 32x16 multiplier stage,
// unless a held result with a last pair behind it backs up in_ready.
// Reset: arst_n clears valid bits and the running sum; mode resets to ReLU,
// clip_limit to 127.
// Stall: while an undelivered result sits in the output register, non-last
// pairs keep accumulating; a second last pair waits in the pipe and backs up
// in_ready only once the stages behind it are full.

`default_nettype none

`include "assert_macros.svh"

module activated_dot_product_core
	import adp_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic                      cfg_index,
	input  wire logic [CFG_W-1:0]          cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic signed [LEFT_W-1:0]  left_value,
	input  wire logic signed [RIGHT_W-1:0] right_value,
	input  wire logic                      last_item,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [SUM_W-1:0]        dot_sum
);

	cfg_t cfg;

	// stage 1: input register
	logic                      valid_s1;
	logic signed [LEFT_W-1:0]  left_s1;
	logic signed [RIGHT_W-1:0] right_s1;
	logic                      last_s1;

	// stage 2: product register
	logic   valid_s2;
	stage_t stage_s2;

	// accumulator and output register
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;
	logic signed [SUM_W-1:0] dot_sum_q;
	logic                    out_valid_q;

	logic out_free;
	logic acc_fire;
	logic s2_take;
	logic s1_take;

	adp_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Flow control: only a last pair needs the output slot.
	assign out_free = !out_valid_q || out_ready;
	assign acc_fire = valid_s2 && (!stage_s2.last || out_free);
	assign s2_take  = !valid_s2 || acc_fire;
	assign s1_take  = !valid_s1 || s2_take;
	assign in_ready = s1_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && in_valid) begin
			left_s1  <= left_value;
			right_s1 <= right_value;
			last_s1  <= last_item;
		end
	end

	adp_mul u_mul (
		.clk      (clk),
		.load     (s2_take && valid_s1),
		.left_s1  (left_s1),
		.right_s1 (right_s1),
		.last_s1  (last_s1),
		.cfg      (cfg),
		.stage_s2 (stage_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_take) begin
			valid_s2 <= valid_s1;
		end
	end

	// 64-bit wrapping accumulate of the sign-extended product
	assign sum_next = sum_q + SUM_W'(stage_s2.prod);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (acc_fire) begin
			sum_q <= stage_s2.last ? '0 : sum_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_fire && stage_s2.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_fire && stage_s2.last)
			dot_sum_q <= stage_s2.zero ? '0 : sum_next;
	end

	assign out_valid = out_valid_q;
	assign dot_sum   = dot_sum_q;

	// A finished vector clears the accumulator.
	`ASSERT_CLK(a_sum_clear, clk, arst_n, acc_fire && stage_s2.last |=> sum_q == '0)
	// Non-positive clip limit forces a zero result.
	`ASSERT_CLK(a_zero_out, clk, arst_n,
		acc_fire && stage_s2.last && stage_s2.zero |=> out_valid && dot_sum == '0)
	// A non-last pair never raises a result from an empty output register.
	`ASSERT_CLK(a_no_spurious, clk, arst_n,
		!out_valid_q && !(acc_fire && stage_s2.last) |=> !out_valid_q)
	// A last pair never overwrites a result that is still held.
	`ASSERT_CLK(a_no_overwrite, clk, arst_n,
		out_valid_q && !out_ready |-> !(acc_fire && stage_s2.last))

endmodule

`default_nettype wire
